// ===== rtl/core/pic_pkg.sv =====
// ============================================================================
// pic_pkg - pendant input conditioner shared definitions
// Types, codes and constants used by the front end, job queue and back end.
// ============================================================================
package pic_pkg;

    // History of inverted port samples
    localparam int HIST_DEPTH = 8;
    localparam int HIST_IDX_W = $clog2(HIST_DEPTH);

    // Job queue between front and back end
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_POLL_CODE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_HOLD = 1'd1;

    localparam logic [7:0] POLL_CODE_RST  = 8'hA5;
    localparam logic [7:0] BLINK_HOLD_RST = 8'd100;

    // Request and result codes
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_BYTE = 1'b1;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_REPLY  = 1'b1;

    // Reply byte positions
    localparam int BYTE_IDX_W = 3;
    localparam logic [BYTE_IDX_W-1:0] BYTE_FILT = 3'd0;
    localparam logic [BYTE_IDX_W-1:0] BYTE_XHI  = 3'd1;
    localparam logic [BYTE_IDX_W-1:0] BYTE_XLO  = 3'd2;
    localparam logic [BYTE_IDX_W-1:0] BYTE_YHI  = 3'd3;
    localparam logic [BYTE_IDX_W-1:0] BYTE_YLO  = 3'd4;

    // LED blink taps on the free-running tick counter
    localparam int BLINK_FAST_BIT = 5;
    localparam int BLINK_SLOW_BIT = 7;

    // Work handed from front to back end
    typedef struct packed {
        logic        kind;
        logic [7:0]  filt;
        logic [7:0]  edges;
        logic        led;
        logic [15:0] x_avg;
        logic [15:0] y_avg;
    } t_job;

    // One result item
    typedef struct packed {
        logic       result_kind;
        logic [7:0] filtered_inputs;
        logic [7:0] rising_edges;
        logic       led_on;
        logic [7:0] tx_byte;
        logic       last_byte;
    } t_rsp;

endpackage

// ===== rtl/core/pic_req_if.sv =====
// ============================================================================
// pic_req_if - request channel
// Valid/ready channel carrying ticks and received serial bytes.
// ============================================================================
interface pic_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [7:0]  port_raw;
    logic [15:0] axis_x_sample;
    logic [15:0] axis_y_sample;
    logic [7:0]  rx_byte;

    modport source (
        output valid, req_type, port_raw, axis_x_sample, axis_y_sample, rx_byte,
        input  ready
    );
    modport sink (
        input  valid, req_type, port_raw, axis_x_sample, axis_y_sample, rx_byte,
        output ready
    );
endinterface

// ===== rtl/core/pic_rsp_if.sv =====
// ============================================================================
// pic_rsp_if - result channel
// Valid/ready channel carrying tick status and reply bytes.
// ============================================================================
interface pic_rsp_if;
    logic       valid;
    logic       ready;
    logic       result_kind;
    logic [7:0] filtered_inputs;
    logic [7:0] rising_edges;
    logic       led_on;
    logic [7:0] tx_byte;
    logic       last_byte;

    modport source (
        output valid, result_kind, filtered_inputs, rising_edges, led_on,
               tx_byte, last_byte,
        input  ready
    );
    modport sink (
        input  valid, result_kind, filtered_inputs, rising_edges, led_on,
               tx_byte, last_byte,
        output ready
    );
endinterface

// ===== rtl/core/pic_front.sv =====
// ============================================================================
// pic_front - request front end
// Accepts one request per cycle while the queue has room; runs debounce,
// axis filters and LED blink, and pushes a job per tick and matching poll byte.
// ============================================================================
module pic_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    pic_req_if.sink                          req,
    input  logic                             i_cfg_we,
    input  logic [pic_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [pic_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_q_full,
    output logic                             o_push,
    output pic_pkg::t_job                    o_job
);

    localparam logic [pic_pkg::HIST_IDX_W-1:0] HIST_LAST =
        pic_pkg::HIST_IDX_W'(pic_pkg::HIST_DEPTH - 1);

    logic [7:0]                      r_poll_code;
    logic [7:0]                      r_blink_hold;
    logic [7:0]                      r_hist [pic_pkg::HIST_DEPTH];
    logic [pic_pkg::HIST_IDX_W-1:0]  r_slot;
    logic [7:0]                      r_deb;
    logic [15:0]                     r_x_avg;
    logic [15:0]                     r_y_avg;
    logic [7:0]                      r_blink_cnt;
    logic [7:0]                      r_hold;
    logic                            r_fast;
    logic                            r_primed;

    logic                            accept;
    logic                            is_tick;
    logic                            poll_fast;
    logic                            poll_slow;
    logic [7:0]                      sample;
    logic [pic_pkg::HIST_IDX_W-1:0]  n_slot;
    logic [7:0]                      all1;
    logic [7:0]                      any1;
    logic [7:0]                      n_deb;
    logic [7:0]                      edges;
    logic [15:0]                     n_x_avg;
    logic [15:0]                     n_y_avg;
    logic                            led;

    assign req.ready = !i_q_full;
    assign accept    = req.valid && req.ready;
    assign is_tick   = (req.req_type == pic_pkg::REQ_TICK);
    assign poll_fast = (req.rx_byte == r_poll_code);
    assign poll_slow = (req.rx_byte == ~r_poll_code);
    assign sample    = ~req.port_raw;
    assign n_slot    = (r_slot == HIST_LAST) ? '0 : r_slot + 1'b1;

    // Debounce over the history with the new sample in place
    always_comb begin
        all1 = 8'hFF;
        any1 = 8'h00;
        for (int n = 0; n < pic_pkg::HIST_DEPTH; n++) begin
            if (n_slot == pic_pkg::HIST_IDX_W'(n)) begin
                all1 = all1 & sample;
                any1 = any1 | sample;
            end else begin
                all1 = all1 & r_hist[n];
                any1 = any1 | r_hist[n];
            end
        end
        if (r_primed) begin
            n_deb = (~r_deb & all1) | (r_deb & any1);
            edges = ~r_deb & n_deb;
        end else begin
            n_deb = sample;
            edges = 8'h00;
        end
    end

    // First-order axis filters, f + x/4 - f/4 modulo 2^16
    always_comb begin
        if (r_primed) begin
            n_x_avg = r_x_avg + (req.axis_x_sample >> 2) - (r_x_avg >> 2);
            n_y_avg = r_y_avg + (req.axis_y_sample >> 2) - (r_y_avg >> 2);
        end else begin
            n_x_avg = req.axis_x_sample;
            n_y_avg = req.axis_y_sample;
        end
    end

    // LED level from the counter value before this tick's increment
    always_comb begin
        if (r_hold != 8'd0) begin
            led = r_fast ? r_blink_cnt[pic_pkg::BLINK_FAST_BIT]
                         : r_blink_cnt[pic_pkg::BLINK_SLOW_BIT];
        end else begin
            led = 1'b0;
        end
    end

    // Job for the back end
    always_comb begin
        o_push = accept && (is_tick || poll_fast || poll_slow);
        if (is_tick) begin
            o_job.kind  = pic_pkg::KIND_STATUS;
            o_job.filt  = n_deb;
            o_job.edges = edges;
            o_job.led   = led;
            o_job.x_avg = '0;
            o_job.y_avg = '0;
        end else begin
            o_job.kind  = pic_pkg::KIND_REPLY;
            o_job.filt  = r_deb;
            o_job.edges = 8'h00;
            o_job.led   = 1'b0;
            o_job.x_avg = r_x_avg;
            o_job.y_avg = r_y_avg;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poll_code  <= pic_pkg::POLL_CODE_RST;
            r_blink_hold <= pic_pkg::BLINK_HOLD_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == pic_pkg::CFG_POLL_CODE) begin
                r_poll_code <= i_cfg_data;
            end else begin
                r_blink_hold <= i_cfg_data;
            end
        end
    end

    // Sample history, loaded whole on the first tick
    always_ff @(posedge i_clk) begin
        if (accept && is_tick) begin
            for (int n = 0; n < pic_pkg::HIST_DEPTH; n++) begin
                if (!r_primed || n_slot == pic_pkg::HIST_IDX_W'(n)) begin
                    r_hist[n] <= sample;
                end
            end
        end
    end

    // Conditioner state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot      <= '0;
            r_deb       <= 8'h00;
            r_x_avg     <= 16'h0000;
            r_y_avg     <= 16'h0000;
            r_blink_cnt <= 8'h00;
            r_hold      <= 8'h00;
            r_fast      <= 1'b0;
            r_primed    <= 1'b0;
        end else if (accept) begin
            if (is_tick) begin
                if (r_primed) begin
                    r_slot <= n_slot;
                end
                r_deb       <= n_deb;
                r_x_avg     <= n_x_avg;
                r_y_avg     <= n_y_avg;
                r_primed    <= 1'b1;
                r_blink_cnt <= r_blink_cnt + 8'd1;
                if (r_hold != 8'd0) begin
                    r_hold <= r_hold - 8'd1;
                end
            end else if (poll_fast || poll_slow) begin
                r_fast <= poll_fast;
                r_hold <= r_blink_hold;
            end
        end
    end

endmodule

// ===== rtl/core/pic_queue.sv =====
// ============================================================================
// pic_queue - job queue
// Small FIFO that decouples the front end from the back end.
// ============================================================================
module pic_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  pic_pkg::t_job   i_job,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output pic_pkg::t_job   o_job
);

    localparam logic [pic_pkg::QUEUE_PTR_W-1:0] PTR_LAST =
        pic_pkg::QUEUE_PTR_W'(pic_pkg::QUEUE_DEPTH - 1);
    localparam logic [pic_pkg::QUEUE_CNT_W-1:0] CNT_FULL =
        pic_pkg::QUEUE_CNT_W'(pic_pkg::QUEUE_DEPTH);

    pic_pkg::t_job                    r_mem [pic_pkg::QUEUE_DEPTH];
    logic [pic_pkg::QUEUE_PTR_W-1:0]  r_wr_ptr;
    logic [pic_pkg::QUEUE_PTR_W-1:0]  r_rd_ptr;
    logic [pic_pkg::QUEUE_CNT_W-1:0]  r_count;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/pic_back.sv =====
// ============================================================================
// pic_back - result back end
// Expands each job into one status result or five reply bytes and holds
// them in an output register.
// ============================================================================
module pic_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  pic_pkg::t_job   i_q_job,
    output logic            o_pop,
    pic_rsp_if.source       rsp
);

    pic_pkg::t_job                   r_job;
    logic                            r_busy;
    logic [pic_pkg::BYTE_IDX_W-1:0]  r_idx;
    pic_pkg::t_rsp                   r_rsp;
    logic                            r_out_valid;

    pic_pkg::t_job                   cur_job;
    logic [pic_pkg::BYTE_IDX_W-1:0]  cur_idx;
    logic                            out_free;
    logic                            emit;
    logic                            is_last;
    logic [7:0]                      tx;
    pic_pkg::t_rsp                   n_rsp;

    assign out_free = !r_out_valid || rsp.ready;
    assign cur_job  = r_busy ? r_job : i_q_job;
    assign cur_idx  = r_busy ? r_idx : pic_pkg::BYTE_FILT;
    assign emit     = out_free && (r_busy || i_q_valid);
    assign o_pop    = out_free && !r_busy && i_q_valid;
    assign is_last  = (cur_job.kind == pic_pkg::KIND_STATUS) || (cur_idx == pic_pkg::BYTE_YLO);

    // Reply byte select
    always_comb begin
        unique case (cur_idx)
            pic_pkg::BYTE_FILT: tx = cur_job.filt;
            pic_pkg::BYTE_XHI:  tx = cur_job.x_avg[15:8];
            pic_pkg::BYTE_XLO:  tx = cur_job.x_avg[7:0];
            pic_pkg::BYTE_YHI:  tx = cur_job.y_avg[15:8];
            pic_pkg::BYTE_YLO:  tx = cur_job.y_avg[7:0];
            default:            tx = 8'h00;
        endcase
    end

    // Result assembly
    always_comb begin
        n_rsp.result_kind     = cur_job.kind;
        n_rsp.filtered_inputs = cur_job.filt;
        n_rsp.rising_edges    = cur_job.edges;
        n_rsp.led_on          = cur_job.led;
        if (cur_job.kind == pic_pkg::KIND_REPLY) begin
            n_rsp.tx_byte   = tx;
            n_rsp.last_byte = is_last;
        end else begin
            n_rsp.tx_byte   = 8'h00;
            n_rsp.last_byte = 1'b0;
        end
    end

    // Job sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (emit) begin
            if (is_last) begin
                r_busy <= 1'b0;
            end else begin
                r_busy <= 1'b1;
                r_idx  <= cur_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_q_job;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_rsp <= n_rsp;
        end
    end

    assign rsp.valid           = r_out_valid;
    assign rsp.result_kind     = r_rsp.result_kind;
    assign rsp.filtered_inputs = r_rsp.filtered_inputs;
    assign rsp.rising_edges    = r_rsp.rising_edges;
    assign rsp.led_on          = r_rsp.led_on;
    assign rsp.tx_byte         = r_rsp.tx_byte;
    assign rsp.last_byte       = r_rsp.last_byte;

endmodule

// ===== rtl/core/pendant_input_conditioner.sv =====
// ============================================================================
// pendant_input_conditioner - pendant input conditioner top level
// Debounces the digital port, filters both joystick axes and answers polls.
// ============================================================================
// The front end takes one request per clock while its two-entry job queue has
// room: a tick updates debounce, filters and LED state in that cycle and yields
// one status result; a poll byte equal to poll_code or its complement yields
// five reply bytes, which the back end sends one per clock from its output
// register while the result side is ready; other bytes give nothing. With
// the result side idle, a result passes the job queue and then the output
// register; behind a poll reply or a stalled result it waits longer.
// There is no clearing pass after reset; the first tick loads the history.
module pendant_input_conditioner (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    pic_req_if.sink                          i_req,
    pic_rsp_if.source                        o_rsp,
    input  logic                             i_cfg_we,
    input  logic [pic_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [pic_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    logic           push;
    logic           pop;
    logic           q_full;
    logic           q_valid;
    pic_pkg::t_job  push_job;
    pic_pkg::t_job  head_job;

    // Request front end
    pic_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .req        (i_req),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_job      (push_job)
    );

    // Job queue
    pic_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (head_job)
    );

    // Result back end
    pic_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_job   (head_job),
        .o_pop     (pop),
        .rsp       (o_rsp)
    );

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_top - pendant input conditioner testbench
// Drives ticks and serial bytes through the request channel, predicts every
// status and reply item in step with the requests, and checks the result
// channel in order, with random gaps on both sides and several settings.
// ============================================================================
module tb_top;
    import pic_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int PHASE_COUNT     = 5;
    localparam int ITEMS_PER_PHASE = 52;
    localparam int MAX_SHOWN       = 10;
    localparam int REPLY_BYTES     = 5;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  port_raw;
        logic [15:0] axis_x;
        logic [15:0] axis_y;
        logic [7:0]  rx_byte;
    } t_req;

    typedef struct packed {
        t_req   req;
        logic   check_fixed;
        t_rsp   fixed;
    } t_step_row;

    localparam t_rsp NO_FIX = '0;

    // Directed opening: first tick, both poll kinds, stray bytes, extremes of
    // the axes, a full clear and a full set of the debounced bits
    localparam int DIR_ROWS = 24;
    localparam t_step_row DIR_TABLE [DIR_ROWS] = '{
        '{'{REQ_TICK, 8'h00, 16'hFFFF, 16'h0000, 8'h00}, 1'b1,
          '{KIND_STATUS, 8'hFF, 8'h00, 1'b0, 8'h00, 1'b0}},
        '{'{REQ_BYTE, 8'h00, 16'h0000, 16'h0000, 8'h00}, 1'b0, NO_FIX},
        '{'{REQ_BYTE, 8'hFF, 16'hFFFF, 16'hFFFF, 8'h5A}, 1'b0, NO_FIX},
        '{'{REQ_BYTE, 8'h00, 16'h0000, 16'h0000, 8'hA5}, 1'b0, NO_FIX},
        '{'{REQ_TICK, 8'hFF, 16'h0000, 16'hFFFF, 8'hFF}, 1'b1,
          '{KIND_STATUS, 8'hFF, 8'h00, 1'b0, 8'h00, 1'b0}},
        '{'{REQ_TICK, 8'hFF, 16'h8000, 16'h0001, 8'h00}, 1'b0, NO_FIX},
        '{'{REQ_TICK, 8'hFF, 16'h0001, 16'h8000, 8'h00}, 1'b0, NO_FIX},
        '{'{REQ_TICK, 8'hFF, 16'h7FFF, 16'hFFFE, 8'h00}, 1'b0, NO_FIX},
        '{'{REQ_TICK, 8'hFF, 16'hFFFF, 16'hFFFF, 8'h00}, 1'b0, NO_FIX},
        '{'{REQ_TICK, 8'hFF, 16'h0000, 16'h0000, 8'h00}, 1'b0, NO_FIX},
        '{'{REQ_TICK, 8'hFF, 16'h1234, 16'hEDCB, 8'h00}, 1'b0, NO_FIX},
        '{'{REQ_TICK, 8'hFF, 16'hFFFF, 16'h0000, 8'h00}, 1'b0, NO_FIX},
        '{'{REQ_BYTE, 8'h00, 16'h0000, 16'h0000, 8'hFF}, 1'b0, NO_FIX},
        '{'{REQ_TICK, 8'h00, 16'h0000, 16'hFFFF, 8'h00}, 1'b0, NO_FIX},
        '{'{REQ_TICK, 8'h00, 16'h0000, 16'hFFFF, 8'h00}, 1'b0, NO_FIX},
        '{'{REQ_TICK, 8'h00, 16'h8000, 16'h8000, 8'h00}, 1'b0, NO_FIX},
        '{'{REQ_TICK, 8'h00, 16'hFFFF, 16'h0000, 8'h00}, 1'b0, NO_FIX},
        '{'{REQ_TICK, 8'h00, 16'hFFFF, 16'h0000, 8'h00}, 1'b0, NO_FIX},
        '{'{REQ_TICK, 8'h00, 16'h0003, 16'hFFFC, 8'h00}, 1'b0, NO_FIX},
        '{'{REQ_TICK, 8'h00, 16'hFFFF, 16'hFFFF, 8'h00}, 1'b0, NO_FIX},
        '{'{REQ_TICK, 8'h00, 16'h0000, 16'h0000, 8'h00}, 1'b0, NO_FIX},
        '{'{REQ_TICK, 8'h55, 16'hFFFF, 16'hFFFF, 8'h00}, 1'b0, NO_FIX},
        '{'{REQ_BYTE, 8'h00, 16'h0000, 16'h0000, 8'hA5}, 1'b0, NO_FIX},
        '{'{REQ_TICK, 8'hAA, 16'h0000, 16'h0000, 8'h00}, 1'b0, NO_FIX}
    };

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                 sink_ready = 1'b0;

    pic_req_if req_if ();
    pic_rsp_if rsp_if ();

    assign rsp_if.ready = sink_ready;

    pendant_input_conditioner uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if),
        .o_rsp      (rsp_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Shadow of the block: configuration, history, filters, LED state
    logic [7:0]  poll_code_r  = POLL_CODE_RST;
    logic [7:0]  hold_ticks_r = BLINK_HOLD_RST;
    logic [7:0]  port_history [HIST_DEPTH];
    int          history_slot = 0;
    logic [7:0]  debounced    = '0;
    logic [15:0] x_average    = '0;
    logic [15:0] y_average    = '0;
    logic [7:0]  blink_count  = '0;
    logic [7:0]  hold_left    = '0;
    logic        fast_blink   = 1'b0;
    logic        primed       = 1'b0;

    // Status and reply items still to come out, oldest first
    t_rsp        rsp_forecast [$];

    int          mismatch_count = 0;
    int          cycle_count    = 0;
    int          stall_left     = 0;
    bit          calm           = 1'b0;
    logic [7:0]  port_level     = 8'hFF;
    t_rsp        got_rsp;
    t_rsp        want_rsp;

    // Advance the shadow by one accepted request and queue what it yields
    task automatic apply_request(input t_req r);
        logic [7:0] sample;
        logic [7:0] all_ones;
        logic [7:0] any_ones;
        logic [7:0] next_bits;
        logic [7:0] edges;
        logic [7:0] b;
        logic [7:0] reply [REPLY_BYTES];
        t_rsp       o;
        o = '0;
        if (r.req_type == REQ_TICK) begin
            sample = ~r.port_raw;
            edges  = '0;
            if (!primed) begin
                // first tick loads everything directly
                for (int k = 0; k < HIST_DEPTH; k++) port_history[k] = sample;
                debounced = sample;
                x_average = r.axis_x;
                y_average = r.axis_y;
                primed    = 1'b1;
            end else begin
                history_slot = (history_slot + 1) % HIST_DEPTH;
                port_history[history_slot] = sample;
                all_ones = '1;
                any_ones = '0;
                for (int k = 0; k < HIST_DEPTH; k++) begin
                    all_ones &= port_history[k];
                    any_ones |= port_history[k];
                end
                next_bits = (~debounced & all_ones) | (debounced & any_ones);
                edges     = ~debounced & next_bits;
                debounced = next_bits;
                // 16-bit wrap comes from the operand widths
                x_average = x_average + (r.axis_x >> 2) - (x_average >> 2);
                y_average = y_average + (r.axis_y >> 2) - (y_average >> 2);
            end
            b = blink_count;
            blink_count = blink_count + 8'd1;
            o.led_on = 1'b0;
            if (hold_left != 0) begin
                hold_left = hold_left - 8'd1;
                o.led_on = fast_blink ? b[BLINK_FAST_BIT] : b[BLINK_SLOW_BIT];
            end
            o.result_kind     = KIND_STATUS;
            o.filtered_inputs = debounced;
            o.rising_edges    = edges;
            rsp_forecast.push_back(o);
        end else if (r.rx_byte == poll_code_r || r.rx_byte == ~poll_code_r) begin
            fast_blink = (r.rx_byte == poll_code_r);
            hold_left  = hold_ticks_r;
            reply[BYTE_FILT] = debounced;
            reply[BYTE_XHI]  = x_average[15:8];
            reply[BYTE_XLO]  = x_average[7:0];
            reply[BYTE_YHI]  = y_average[15:8];
            reply[BYTE_YLO]  = y_average[7:0];
            for (int k = 0; k < REPLY_BYTES; k++) begin
                o.result_kind     = KIND_REPLY;
                o.filtered_inputs = debounced;
                o.tx_byte         = reply[k];
                o.last_byte       = (k == REPLY_BYTES - 1);
                rsp_forecast.push_back(o);
            end
        end
    endtask

    // Present one request after a random gap and wait for it to be taken
    task automatic send_request(input t_req r, input logic check_fixed, input t_rsp fixed);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid         <= 1'b1;
        req_if.req_type      <= r.req_type;
        req_if.port_raw      <= r.port_raw;
        req_if.axis_x_sample <= r.axis_x;
        req_if.axis_y_sample <= r.axis_y;
        req_if.rx_byte       <= r.rx_byte;
        do @(posedge i_clk); while (!req_if.ready);
        apply_request(r);
        if (check_fixed) rsp_forecast[rsp_forecast.size() - 1] = fixed;
        @(negedge i_clk);
    endtask

    // Hold off until every queued item is out and the pipeline is empty
    task automatic settle();
        req_if.valid <= 1'b0;
        while (rsp_forecast.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_POLL_CODE:  poll_code_r  = val;
            CFG_BLINK_HOLD: hold_ticks_r = val;
            default: ;
        endcase
    endtask

    function automatic logic [15:0] pick_axis();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h8000;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // Mostly ticks with a port that holds long enough to debounce, then polls
    // of both kinds, then stray bytes that should be dropped
    task automatic random_request(output t_req r, output bit counts);
        int sel;
        int m;
        sel = $urandom_range(0, 99);
        r.port_raw = 8'($urandom_range(0, 255));
        r.axis_x   = pick_axis();
        r.axis_y   = pick_axis();
        r.rx_byte  = 8'($urandom_range(0, 255));
        counts     = 1'b1;
        if (sel < 72) begin
            m = $urandom_range(0, 9);
            if (m >= 9)
                port_level = 8'($urandom_range(0, 255));
            else if (m >= 6)
                port_level = port_level ^ (8'd1 << $urandom_range(0, 7));
            r.req_type = REQ_TICK;
            r.port_raw = port_level;
        end else if (sel < 90) begin
            r.req_type = REQ_BYTE;
            r.rx_byte  = $urandom_range(0, 1) ? poll_code_r : ~poll_code_r;
        end else begin
            r.req_type = REQ_BYTE;
            counts     = 1'b0;
        end
    endtask

    // Result side: random stalls on ready
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            sink_ready <= 1'b0;
            stall_left--;
        end else begin
            sink_ready <= 1'b1;
        end
    end

    // Result side: compare each accepted item with the oldest forecast
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            got_rsp.result_kind     = rsp_if.result_kind;
            got_rsp.filtered_inputs = rsp_if.filtered_inputs;
            got_rsp.rising_edges    = rsp_if.rising_edges;
            got_rsp.led_on          = rsp_if.led_on;
            got_rsp.tx_byte         = rsp_if.tx_byte;
            got_rsp.last_byte       = rsp_if.last_byte;
            if (rsp_forecast.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_SHOWN)
                    $display("%0t: unexpected item kind=%0d filt=%h edge=%h",
                             $realtime, got_rsp.result_kind, got_rsp.filtered_inputs,
                             got_rsp.rising_edges, " led=%0d tx=%h last=%0d",
                             got_rsp.led_on, got_rsp.tx_byte, got_rsp.last_byte);
            end else begin
                want_rsp = rsp_forecast.pop_front();
                if (got_rsp.result_kind !== want_rsp.result_kind
                    || got_rsp.filtered_inputs !== want_rsp.filtered_inputs
                    || got_rsp.rising_edges !== want_rsp.rising_edges
                    || got_rsp.led_on !== want_rsp.led_on
                    || got_rsp.tx_byte !== want_rsp.tx_byte
                    || got_rsp.last_byte !== want_rsp.last_byte) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_SHOWN)
                        $display("%0t: exp kind=%0d filt=%h edge=%h led=%0d tx=%h last=%0d",
                                 $realtime, want_rsp.result_kind,
                                 want_rsp.filtered_inputs, want_rsp.rising_edges,
                                 want_rsp.led_on, want_rsp.tx_byte, want_rsp.last_byte,
                                 " / got kind=%0d filt=%h edge=%h led=%0d tx=%h last=%0d",
                                 got_rsp.result_kind, got_rsp.filtered_inputs,
                                 got_rsp.rising_edges, got_rsp.led_on,
                                 got_rsp.tx_byte, got_rsp.last_byte);
                end
            end
            stall_left = calm ? 0 : $urandom_range(0, 16);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("pendant_input_conditioner verification failed");
            $finish;
        end
    end

    // Main sequence
    initial begin
        int         placed;
        bit         counts;
        t_req       item;
        logic [7:0] code_val;
        logic [7:0] hold_val;
        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_idx            = '0;
        i_cfg_data           = '0;
        req_if.valid         = 1'b0;
        req_if.req_type      = REQ_TICK;
        req_if.port_raw      = '0;
        req_if.axis_x_sample = '0;
        req_if.axis_y_sample = '0;
        req_if.rx_byte       = '0;
        for (int k = 0; k < HIST_DEPTH; k++) port_history[k] = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int row = 0; row < DIR_ROWS; row++)
            send_request(DIR_TABLE[row].req, DIR_TABLE[row].check_fixed,
                         DIR_TABLE[row].fixed);

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            settle();
            case (phase)
                0: begin code_val = 8'h00; hold_val = 8'd0;   end
                1: begin code_val = 8'hFF; hold_val = 8'd255; end
                2: begin
                    code_val = 8'($urandom_range(0, 255));
                    hold_val = 8'($urandom_range(1, 254));
                end
                3: begin code_val = 8'h3C; hold_val = 8'd1;   end
                default: begin
                    code_val = 8'($urandom_range(0, 255));
                    hold_val = 8'($urandom_range(0, 255));
                end
            endcase
            write_reg(CFG_POLL_CODE, code_val);
            write_reg(CFG_BLINK_HOLD, hold_val);
            placed = 0;
            while (placed < ITEMS_PER_PHASE) begin
                // stretches without any idling on either side
                if (placed % 25 == 0) calm = (phase == 1) || ($urandom_range(0, 3) == 0);
                random_request(item, counts);
                send_request(item, 1'b0, NO_FIX);
                if (counts) placed++;
            end
        end
        calm = 1'b0;

        settle();
        if (mismatch_count == 0)
            $display("pendant_input_conditioner verification clean");
        else
            $display("pendant_input_conditioner verification failed");
        $finish;
    end

endmodule
